// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising edge, switched off while reset is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache policy block.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int Capacity = 16;
  localparam int SlotW    = $clog2(Capacity);
  localparam int OccW     = $clog2(Capacity + 1);
  localparam int CapW     = 5;
  localparam int KeyW     = 32;
  localparam int ValW     = 32;
  localparam int CntW     = 32;

  localparam logic [CapW-1:0] CapReset = CapW'(16);
  localparam logic            ModeGet  = 1'b0;
  localparam logic            ModePut  = 1'b1;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [OccW-1:0]  occ_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef struct packed {
    logic                   mode;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic signed [ValW-1:0] read_value;
    logic                   evicted;
    logic signed [KeyW-1:0] evicted_key;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // One slot as seen at the scan read port
  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
    cnt_t                   count;
    slot_t                  rank;
  } slot_rd_t;

  // Update command from the sequencer to the slot store
  typedef struct packed {
    logic                   dec_en;
    slot_t                  dec_rank;
    logic                   touch_en;
    slot_t                  touch_slot;
    slot_t                  touch_rank;
    logic                   wr_value;
    logic signed [ValW-1:0] value;
    logic                   evict_en;
    slot_t                  victim;
    logic                   ins_en;
    slot_t                  ins_slot;
    logic signed [KeyW-1:0] ins_key;
    slot_t                  ins_rank;
  } upd_t;

endpackage

// ===== rtl/lfu_cmp.sv =====
// ----------------------------------------------------------------------------
// lfu_cmp
// Shared compare unit: key match and victim ordering for one slot.
// ----------------------------------------------------------------------------
module lfu_cmp (
  input  lfu_pkg::slot_rd_t       rd,
  input  logic signed [31:0]      key,
  input  logic                    best_valid,
  input  lfu_pkg::cnt_t           best_cnt,
  input  lfu_pkg::slot_t          best_rank,
  output logic                    match,
  output logic                    better
);

  logic cnt_lt;
  logic cnt_eq;

  assign match  = rd.valid && (rd.key == key);
  assign cnt_lt = rd.count < best_cnt;
  assign cnt_eq = rd.count == best_cnt;
  // lower count wins, ties to the older rank
  assign better = rd.valid &&
                  (!best_valid || cnt_lt || (cnt_eq && (rd.rank < best_rank)));

endmodule

// ===== rtl/lfu_store.sv =====
// ----------------------------------------------------------------------------
// lfu_store
// Slot storage: valid bits, keys, values, use counts and recency ranks.
// ----------------------------------------------------------------------------
module lfu_store (
  input  logic              clk,
  input  logic              rst,
  input  lfu_pkg::slot_t    rd_idx,
  output lfu_pkg::slot_rd_t rd,
  input  lfu_pkg::upd_t     upd
);

  logic                           slot_valid [lfu_pkg::Capacity];
  logic signed [lfu_pkg::KeyW-1:0] slot_key   [lfu_pkg::Capacity];
  logic signed [lfu_pkg::ValW-1:0] slot_value [lfu_pkg::Capacity];
  lfu_pkg::cnt_t                  slot_count [lfu_pkg::Capacity];
  lfu_pkg::slot_t                 slot_rank  [lfu_pkg::Capacity];

  assign rd.valid = slot_valid[rd_idx];
  assign rd.key   = slot_key[rd_idx];
  assign rd.value = slot_value[rd_idx];
  assign rd.count = slot_count[rd_idx];
  assign rd.rank  = slot_rank[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lfu_pkg::Capacity; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      if (upd.evict_en) begin
        slot_valid[upd.victim] <= 1'b0;
      end
      // insert may reuse the slot just freed
      if (upd.ins_en) begin
        slot_valid[upd.ins_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    // close the rank gap left by a touched or evicted entry
    for (int i = 0; i < lfu_pkg::Capacity; i++) begin
      if (upd.dec_en && slot_valid[i] && (slot_rank[i] > upd.dec_rank)) begin
        slot_rank[i] <= slot_rank[i] - lfu_pkg::SlotW'(1);
      end
    end
    if (upd.touch_en) begin
      slot_rank[upd.touch_slot] <= upd.touch_rank;
      if (slot_count[upd.touch_slot] != '1) begin
        slot_count[upd.touch_slot] <= slot_count[upd.touch_slot] + lfu_pkg::CntW'(1);
      end
      if (upd.wr_value) begin
        slot_value[upd.touch_slot] <= upd.value;
      end
    end
    if (upd.ins_en) begin
      slot_key[upd.ins_slot]   <= upd.ins_key;
      slot_value[upd.ins_slot] <= upd.value;
      slot_count[upd.ins_slot] <= lfu_pkg::CntW'(1);
      slot_rank[upd.ins_slot]  <= upd.ins_rank;
    end
  end

endmodule

// ===== rtl/lfu_seq.sv =====
// ----------------------------------------------------------------------------
// lfu_seq
// Sequencer: request capture, slot scan through the compare unit, update
// decision and response register.
// ----------------------------------------------------------------------------
module lfu_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  lfu_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output lfu_pkg::rsp_t             rsp_data,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CapW-1:0]  cfg_wdata,
  output lfu_pkg::slot_t            rd_idx,
  input  lfu_pkg::slot_rd_t         rd,
  output lfu_pkg::upd_t             upd
);

  lfu_pkg::state_t state;
  lfu_pkg::state_t state_next;

  logic [lfu_pkg::CapW-1:0] cap_cfg;
  lfu_pkg::occ_t            cap_eff;
  lfu_pkg::occ_t            cap_q;
  lfu_pkg::occ_t            occ;
  lfu_pkg::occ_t            occ_next;
  lfu_pkg::req_t            req_q;
  lfu_pkg::slot_t           idx;

  logic                            found;
  lfu_pkg::slot_t                  hit_slot;
  logic signed [lfu_pkg::ValW-1:0] hit_val;
  lfu_pkg::slot_t                  hit_rank;

  logic                            have_victim;
  lfu_pkg::slot_t                  victim;
  lfu_pkg::cnt_t                   vcnt;
  lfu_pkg::slot_t                  vrank;
  logic signed [lfu_pkg::KeyW-1:0] vkey;

  logic           have_free;
  lfu_pkg::slot_t free_slot;

  logic           cmp_match;
  logic           cmp_better;
  logic           scan_last;
  logic           evict;
  lfu_pkg::occ_t  occ_m1;
  lfu_pkg::occ_t  ins_rank;
  lfu_pkg::upd_t  upd_d;
  lfu_pkg::rsp_t  rsp_next;
  lfu_pkg::rsp_t  rsp_q;

  lfu_cmp u_cmp (
    .rd         (rd),
    .key        (req_q.key),
    .best_valid (have_victim),
    .best_cnt   (vcnt),
    .best_rank  (vrank),
    .match      (cmp_match),
    .better     (cmp_better)
  );

  assign rd_idx    = idx;
  assign scan_last = idx == lfu_pkg::slot_t'(lfu_pkg::Capacity - 1);
  assign cap_eff   = (cap_cfg > lfu_pkg::CapW'(lfu_pkg::Capacity)) ?
                     lfu_pkg::OccW'(lfu_pkg::Capacity) : lfu_pkg::OccW'(cap_cfg);
  assign occ_m1    = occ - lfu_pkg::OccW'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (req_valid) state_next = lfu_pkg::ST_SCAN;
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_last) state_next = lfu_pkg::ST_UPDATE;
      end
      lfu_pkg::ST_UPDATE: begin
        state_next = lfu_pkg::ST_RESP;
      end
      lfu_pkg::ST_RESP: begin
        if (rsp_ready) state_next = lfu_pkg::ST_IDLE;
      end
      default: state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    upd       = '0;
    unique case (state)
      lfu_pkg::ST_IDLE:   req_ready = 1'b1;
      lfu_pkg::ST_SCAN:   ;
      lfu_pkg::ST_UPDATE: upd = upd_d;
      lfu_pkg::ST_RESP:   rsp_valid = 1'b1;
      default:            ;
    endcase
  end

  assign rsp_data = rsp_q;

  // update decision from the scan results
  always_comb begin
    upd_d    = '0;
    occ_next = occ;
    evict    = 1'b0;
    ins_rank = occ;
    rsp_next.hit         = found;
    rsp_next.read_value  = '0;
    rsp_next.evicted     = 1'b0;
    rsp_next.evicted_key = '0;
    upd_d.value          = req_q.value;
    upd_d.ins_key        = req_q.key;
    upd_d.touch_slot     = hit_slot;
    upd_d.touch_rank     = occ_m1[lfu_pkg::SlotW-1:0];
    upd_d.victim         = victim;
    upd_d.dec_rank       = hit_rank;
    if (req_q.mode == lfu_pkg::ModeGet) begin
      rsp_next.read_value = found ? hit_val : '1;
      upd_d.touch_en      = found;
      upd_d.dec_en        = found;
    end else if (cap_q != '0) begin
      if (found) begin
        upd_d.touch_en = 1'b1;
        upd_d.dec_en   = 1'b1;
        upd_d.wr_value = 1'b1;
      end else begin
        evict = occ >= cap_q;
        if (evict) begin
          upd_d.evict_en       = 1'b1;
          upd_d.dec_en         = 1'b1;
          upd_d.dec_rank       = vrank;
          rsp_next.evicted     = 1'b1;
          rsp_next.evicted_key = vkey;
          ins_rank             = occ_m1;
          // first free slot after eviction
          upd_d.ins_slot       = (have_free && (free_slot < victim)) ? free_slot : victim;
        end else begin
          occ_next       = occ + lfu_pkg::OccW'(1);
          upd_d.ins_slot = free_slot;
        end
        upd_d.ins_en   = 1'b1;
        upd_d.ins_rank = ins_rank[lfu_pkg::SlotW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lfu_pkg::ST_IDLE;
      cap_cfg <= lfu_pkg::CapReset;
      occ     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap_cfg <= cfg_wdata;
      end
      if (state == lfu_pkg::ST_UPDATE) begin
        occ <= occ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lfu_pkg::ST_IDLE && req_valid) begin
      req_q       <= req_data;
      cap_q       <= cap_eff;
      idx         <= '0;
      found       <= 1'b0;
      have_victim <= 1'b0;
      have_free   <= 1'b0;
    end
    if (state == lfu_pkg::ST_SCAN) begin
      idx <= idx + lfu_pkg::SlotW'(1);
      if (cmp_match) begin
        found    <= 1'b1;
        hit_slot <= idx;
        hit_val  <= rd.value;
        hit_rank <= rd.rank;
      end
      if (cmp_better) begin
        have_victim <= 1'b1;
        victim      <= idx;
        vcnt        <= rd.count;
        vrank       <= rd.rank;
        vkey        <= rd.key;
      end
      if (!rd.valid && !have_free) begin
        have_free <= 1'b1;
        free_slot <= idx;
      end
    end
    if (state == lfu_pkg::ST_UPDATE) begin
      rsp_q <= rsp_next;
    end
  end

endmodule

// ===== rtl/lfu_cache_policy.sv =====
// Flow: a request is accepted in idle, then scanned over every slot, then the update
// state writes the store and registers the response. A new request is taken only
// after the response has been accepted and the block is back in idle.
// The scan walks one slot a cycle through one compare unit.
// Reset (rst, synchronous, active high): store empty, capacity 16, idle.
// Keys, values, counts and ranks are not cleared; only valid slots are read.
// ----------------------------------------------------------------------------
// lfu_cache_policy
// Key-value store with least-frequently-used replacement and LRU tie-break.
// ----------------------------------------------------------------------------
module lfu_cache_policy (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  lfu_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output lfu_pkg::rsp_t             rsp_data,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CapW-1:0]  cfg_wdata
);

  // Request flow:
  //   idle   - ready high; a request is captured with the clamped capacity
  //   scan   - one slot a cycle: key match, free slot, and the running victim
  //            (lowest count, then lowest recency rank)
  //   update - touch, overwrite, evict and/or insert in the store
  //   resp   - response held until taken; no new request meanwhile

  lfu_pkg::slot_t    rd_idx;
  lfu_pkg::slot_rd_t rd;
  lfu_pkg::upd_t     upd;

  lfu_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_idx    (rd_idx),
    .rd        (rd),
    .upd       (upd)
  );

  // Slot store: single scan read port, all writes applied in the update cycle
  lfu_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd     (rd),
    .upd    (upd)
  );

endmodule

// ===== rtl/lfu_checker.sv =====
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks of the LFU cache policy block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input lfu_pkg::rsp_t rsp_data
);

  `ASSERT_CLK(a_one_in_flight, !(req_ready && rsp_valid), "ready while response pending")
  `ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready && !rsp_valid, "request not held")
  `ASSERT_NEXT(a_rsp_once, rsp_valid && rsp_ready, !rsp_valid, "response repeated")
  `ASSERT_IMPL(a_evk_zero, rsp_valid && !rsp_data.evicted, rsp_data.evicted_key == '0, "stray evicted key")
  `ASSERT_IMPL(a_evict_miss, rsp_valid && rsp_data.evicted, !rsp_data.hit, "eviction on a hit")

endmodule

bind lfu_cache_policy lfu_checker u_lfu_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lfu_cache_policy: a clocked driver feeds get and put
// requests from a backlog, a clocked monitor compares each response with a
// software copy of the LFU store (LRU tie-break). Random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int ResetCycles  = 7;
  localparam int SettleCycles = 24;      // block latency plus margin
  localparam int CycleLimit   = 800000;
  localparam int PhaseItems   = 58;
  localparam int MaxReports   = 10;
  localparam int NumPhases    = 10;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_ready;
  lfu_pkg::req_t            req_data  = '0;
  logic                     rsp_valid;
  logic                     rsp_ready = 1'b0;
  lfu_pkg::rsp_t            rsp_data;
  logic                     cfg_we    = 1'b0;
  logic [lfu_pkg::CapW-1:0] cfg_wdata = '0;

  lfu_cache_policy dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the store: occupancy bits, keys, values, use counts and
  // recency ranks (0 = least recently touched).
  // ---------------------------------------------------------------------------
  logic                            shadow_used [lfu_pkg::Capacity];
  logic signed [lfu_pkg::KeyW-1:0] shadow_key  [lfu_pkg::Capacity];
  logic signed [lfu_pkg::ValW-1:0] shadow_val  [lfu_pkg::Capacity];
  lfu_pkg::cnt_t                   shadow_cnt  [lfu_pkg::Capacity];
  int unsigned                     shadow_rank [lfu_pkg::Capacity];
  int unsigned                     shadow_fill;
  logic [lfu_pkg::CapW-1:0]        shadow_cap;

  lfu_pkg::req_t queued_reqs[$];       // requests waiting for the driver
  lfu_pkg::rsp_t expected_replies[$];  // predicted responses, oldest first

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  bit   idle_on        = 1'b1;
  bit   req_accepted   = 1'b0;
  int   req_gap        = 0;
  int   rsp_stall      = 0;

  // Slide every entry more recent than rank r down by one.
  function automatic void close_rank_gap(int unsigned r);
    for (int i = 0; i < lfu_pkg::Capacity; i++) begin
      if (shadow_used[i] && shadow_rank[i] > r) shadow_rank[i]--;
    end
  endfunction

  // Hit on slot s: becomes most recent, count saturates at all ones.
  function automatic void promote(int s);
    close_rank_gap(shadow_rank[s]);
    shadow_rank[s] = shadow_fill - 1;
    if (shadow_cnt[s] != '1) shadow_cnt[s]++;
  endfunction

  // Applies one request to the shadow store and returns the response it owes.
  function automatic lfu_pkg::rsp_t lfu_lookup(lfu_pkg::req_t rq);
    lfu_pkg::rsp_t r;
    int            cap_eff;
    int            s;
    int            victim;
    int            free_idx;
    r = '0;
    cap_eff = (int'(shadow_cap) > lfu_pkg::Capacity) ? lfu_pkg::Capacity : int'(shadow_cap);
    s = -1;
    for (int i = 0; i < lfu_pkg::Capacity; i++) begin
      if (s < 0 && shadow_used[i] && shadow_key[i] == rq.key) s = i;
    end
    r.hit = (s >= 0);
    if (rq.mode == lfu_pkg::ModeGet) begin
      if (s >= 0) begin
        r.read_value = shadow_val[s];
        promote(s);
      end else begin
        r.read_value = -1;
      end
    end else if (cap_eff != 0) begin
      if (s >= 0) begin
        shadow_val[s] = rq.value;
        promote(s);
      end else begin
        victim   = -1;
        free_idx = -1;
        // full (or capacity lowered below fill): evict exactly one entry
        if (int'(shadow_fill) >= cap_eff) begin
          for (int i = 0; i < lfu_pkg::Capacity; i++) begin
            if (shadow_used[i] && (victim < 0 || shadow_cnt[i] < shadow_cnt[victim] ||
                (shadow_cnt[i] == shadow_cnt[victim] &&
                 shadow_rank[i] < shadow_rank[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            r.evicted     = 1'b1;
            r.evicted_key = shadow_key[victim];
            shadow_used[victim] = 1'b0;
            close_rank_gap(shadow_rank[victim]);
            shadow_fill--;
          end
        end
        for (int i = 0; i < lfu_pkg::Capacity; i++) begin
          if (free_idx < 0 && !shadow_used[i]) free_idx = i;
        end
        if (free_idx >= 0) begin
          shadow_used[free_idx] = 1'b1;
          shadow_key[free_idx]  = rq.key;
          shadow_val[free_idx]  = rq.value;
          shadow_cnt[free_idx]  = 1;
          shadow_rank[free_idx] = shadow_fill;
          shadow_fill++;
        end
      end
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: acceptance seen at the rising edge, drive at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && req_valid && req_ready) begin
      expected_replies.push_back(lfu_lookup(req_data));
      req_accepted = 1'b1;
    end
  end

  always @(negedge clk) begin
    lfu_pkg::req_t nxt;
    if (!rst && (!req_valid || req_accepted)) begin
      req_accepted = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (queued_reqs.size() != 0) begin
        nxt = queued_reqs.pop_front();
        req_data  <= nxt;
        req_valid <= 1'b1;
        req_gap   = idle_on ? gap_length() : 0;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side: random back-pressure, ready independent of valid
  always @(negedge clk) begin
    if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 30) rsp_stall = gap_length();
    end
  end

  // Monitor: every accepted response against the oldest prediction
  always @(posedge clk) begin
    lfu_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_replies.size() == 0) begin
        if (mismatch_count < MaxReports)
          $display("response with no request outstanding: hit=%0d rv=%0d ev=%0d ek=%0d",
                   rsp_data.hit, rsp_data.read_value, rsp_data.evicted,
                   rsp_data.evicted_key);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (rsp_data.hit !== want.hit || rsp_data.read_value !== want.read_value ||
            rsp_data.evicted !== want.evicted ||
            rsp_data.evicted_key !== want.evicted_key) begin
          if (mismatch_count < MaxReports)
            $display("bad response: exp hit=%0d rv=%0d ev=%0d ek=%0d got hit=%0d rv=%0d ev=%0d ek=%0d",
                     want.hit, want.read_value, want.evicted, want.evicted_key,
                     rsp_data.hit, rsp_data.read_value, rsp_data.evicted,
                     rsp_data.evicted_key);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("lfu_cache_policy: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(logic m, logic signed [lfu_pkg::KeyW-1:0] k,
                          logic signed [lfu_pkg::ValW-1:0] v);
    lfu_pkg::req_t q;
    q.mode  = m;
    q.key   = k;
    q.value = v;
    queued_reqs.push_back(q);
  endtask

  // Sender holds off until every outstanding request has been answered.
  task automatic wait_drained();
    while (queued_reqs.size() != 0 || req_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_capacity(logic [lfu_pkg::CapW-1:0] c);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    shadow_cap = c;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [lfu_pkg::CapW-1:0]        phase_cap [NumPhases];
    logic signed [lfu_pkg::KeyW-1:0] key_pool  [24];
    int                              pool_n;
    int                              p;
    logic signed [lfu_pkg::KeyW-1:0] k;

    phase_cap = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd2, 5'd17, 5'd8, 5'd3, 5'd16};
    for (int i = 0; i < lfu_pkg::Capacity; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_cnt[i]  = '0;
      shadow_rank[i] = 0;
    end
    shadow_fill = 0;
    shadow_cap  = lfu_pkg::CapReset;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme keys and values at the reset capacity
    push_req(lfu_pkg::ModeGet, 32'sh8000_0000, 0);                 // miss on empty store
    push_req(lfu_pkg::ModePut, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_req(lfu_pkg::ModePut, 32'sh7FFF_FFFF, 32'sh8000_0000);
    push_req(lfu_pkg::ModeGet, 32'sh8000_0000, -1);                // hit, value ignored
    push_req(lfu_pkg::ModeGet, -1, 0);
    push_req(lfu_pkg::ModePut, 0, -1);
    push_req(lfu_pkg::ModePut, 32'sh7FFF_FFFF, 0);                 // overwrite present key
    push_req(lfu_pkg::ModeGet, 32'sh7FFF_FFFF, 0);
    wait_drained();

    // capacity lowered below occupancy: one eviction per new key
    write_capacity(5'd2);
    push_req(lfu_pkg::ModePut, 1, 11);
    push_req(lfu_pkg::ModePut, 2, 22);
    push_req(lfu_pkg::ModeGet, 1, 0);
    push_req(lfu_pkg::ModeGet, 1, 0);
    push_req(lfu_pkg::ModePut, 3, 33);                             // lower count loses
    push_req(lfu_pkg::ModePut, 4, 44);
    wait_drained();

    // capacity zero: puts ignored, gets still served
    write_capacity(5'd0);
    push_req(lfu_pkg::ModePut, 5, 55);
    push_req(lfu_pkg::ModePut, 1, 99);                             // key evicted earlier, no insert
    push_req(lfu_pkg::ModeGet, 1, 0);
    push_req(lfu_pkg::ModeGet, 5, 0);
    wait_drained();

    // capacity beyond the slot count clamps
    write_capacity(5'd31);
    push_req(lfu_pkg::ModePut, 10, 100);
    push_req(lfu_pkg::ModePut, 11, 110);
    push_req(lfu_pkg::ModeGet, 10, 0);
    wait_drained();

    // random phases, small key pools so hits and evictions are common
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_capacity(phase_cap[ph]);
      idle_on = (ph != 3 && ph != 7);
      pool_n = ((int'(phase_cap[ph]) > lfu_pkg::Capacity) ?
                lfu_pkg::Capacity : int'(phase_cap[ph])) + 4;
      for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
      for (int n = 0; n < PhaseItems; n++) begin
        p = $urandom_range(0, 99);
        if (p < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
        else if (p < 90) k = (p[0]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else k = $urandom;
        push_req(logic'($urandom_range(0, 1)), k, $urandom);
        if (n == PhaseItems / 2) wait_drained();
      end
      wait_drained();
    end

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("lfu_cache_policy: match");
    end else begin
      $display("lfu_cache_policy: mismatch");
    end
    $finish;
  end

endmodule
